// File: hw/rtl/mesh_face_and_vertex_normals_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mesh normal block
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef MESH_FACE_AND_VERTEX_NORMALS_ASSERT_SVH
`define MESH_FACE_AND_VERTEX_NORMALS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFVN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfvn assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MFVN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfvn assertion failed");

`endif

// File: hw/rtl/mfvn_pkg.sv
// ----------------------------------------------------------------------------
// Mesh normal package
// Types, widths and state codes shared by the mesh normal block.
// ----------------------------------------------------------------------------
package mfvn_pkg;

   localparam int unsigned VERTEX_DEPTH_DEFAULT = 4096;
   localparam int unsigned INDEX_W = 12;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned EDGE_W  = 17;
   localparam int unsigned SUM_W   = 20;
   localparam int unsigned NORM_W  = 16;
   localparam int unsigned VEC_W   = 35;
   localparam int unsigned ONE_Q14 = 16384;

   // Request mode codes.
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_FACE = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   typedef struct packed {
      logic [1:0]                mode;
      logic [INDEX_W-1:0]        index_a;
      logic [INDEX_W-1:0]        index_b;
      logic [INDEX_W-1:0]        index_c;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
   } req_type;

   typedef struct packed {
      logic                      is_face;
      logic signed [NORM_W-1:0]  norm_x;
      logic signed [NORM_W-1:0]  norm_y;
      logic signed [NORM_W-1:0]  norm_z;
      logic                      degenerate;
   } rsp_type;

   // Control towards the normalizer.
   typedef struct packed {
      logic                      start;
      logic signed [VEC_W-1:0]   vec_x;
      logic signed [VEC_W-1:0]   vec_y;
      logic signed [VEC_W-1:0]   vec_z;
   } norm_req_type;

   // Status back from the normalizer.
   typedef struct packed {
      logic                      done;
      logic                      degen;
      logic signed [NORM_W-1:0]  n_x;
      logic signed [NORM_W-1:0]  n_y;
      logic signed [NORM_W-1:0]  n_z;
   } norm_rsp_type;

   typedef enum logic [2:0] {
      N_IDLE, N_SHIFT, N_SQUARE, N_SQRT, N_DIV_SETUP, N_DIV, N_DONE
   } norm_state_type;

   typedef enum logic [3:0] {
      T_CLEAR, T_IDLE, T_LOAD, T_FRA, T_FRB, T_FRC, T_FCAP, T_EDGE, T_MUL,
      T_RD, T_RDCAP, T_NGO, T_NWAIT, T_ACC_RD, T_ACC_WR
   } top_state_type;

   // True when a vertex index lies inside the store.
   function automatic logic idx_ok(logic [INDEX_W-1:0] idx, int unsigned depth);
      return {20'd0, idx} < depth;
   endfunction

endpackage

// File: hw/rtl/mfvn_norm.sv
// ----------------------------------------------------------------------------
// Mesh normal vector normalizer
// Scales an integer vector to unit length in Q1.14 with an iterative shifter,
// one squaring multiplier, a bit-pair square root and a restoring divider.
// ----------------------------------------------------------------------------
module mfvn_norm
   import mfvn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  norm_req_type norm_req,
   output norm_rsp_type norm_rsp
);

   localparam int unsigned LEN_W = 62;
   localparam int unsigned DIV_W = 46;

   norm_state_type state_ff, state_in;
   logic [VEC_W-1:0]        m_ff [3];
   logic [VEC_W-1:0]        m_in [3];
   logic                    neg_ff [3];
   logic                    neg_in [3];
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        root_ff, root_in;
   logic [LEN_W-1:0]        bit_ff, bit_in;
   logic [1:0]              comp_ff, comp_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [DIV_W-1:0]        num_ff, num_in;
   logic [DIV_W-1:0]        dvs_ff, dvs_in;
   logic [NORM_W-1:0]       q_ff, q_in;
   logic signed [NORM_W-1:0] n_ff [3];
   logic signed [NORM_W-1:0] n_in [3];
   logic                    degen_ff, degen_in;

   logic [VEC_W-1:0]        vec_sel [3];
   logic [29:0]             m_cur;
   logic [59:0]             square;
   logic [LEN_W-1:0]        trial;
   logic [30:0]             root_s;
   logic                    any_high, all_low, all_zero, ge;
   logic [NORM_W-1:0]       q_clamped;

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      for (int i = 0; i < 3; i++) begin
         m_ff[i]   <= m_in[i];
         neg_ff[i] <= neg_in[i];
         n_ff[i]   <= n_in[i];
      end
      len_ff   <= len_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      comp_ff  <= comp_in;
      cnt_ff   <= cnt_in;
      num_ff   <= num_in;
      dvs_ff   <= dvs_in;
      q_ff     <= q_in;
      degen_ff <= degen_in;
   end

   // Shared helpers for the current component.
   always_comb begin
      vec_sel[0] = norm_req.vec_x;
      vec_sel[1] = norm_req.vec_y;
      vec_sel[2] = norm_req.vec_z;
      any_high = 1'b0;
      all_low  = 1'b1;
      for (int i = 0; i < 3; i++) begin
         any_high = any_high | (|m_ff[i][VEC_W-1:30]);
         all_low  = all_low & ~(|m_ff[i][VEC_W-1:29]);
      end
      all_zero = (norm_req.vec_x == '0) && (norm_req.vec_y == '0) &&
                 (norm_req.vec_z == '0);
      m_cur  = m_ff[comp_ff][29:0];
      square = m_cur * m_cur;
      trial  = root_ff + bit_ff;
      root_s = root_ff[30:0];
      ge     = num_ff >= dvs_ff;
   end

   // Sequencer for shifting, squaring, square root and division.
   always_comb begin
      state_in = state_ff;
      for (int i = 0; i < 3; i++) begin
         m_in[i]   = m_ff[i];
         neg_in[i] = neg_ff[i];
         n_in[i]   = n_ff[i];
      end
      len_in    = len_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      comp_in   = comp_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      dvs_in    = dvs_ff;
      q_in      = q_ff;
      degen_in  = degen_ff;
      q_clamped = '0;

      case (state_ff)
         N_IDLE: begin
            if (norm_req.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = vec_sel[i][VEC_W-1];
                  m_in[i]   = vec_sel[i][VEC_W-1] ? (~vec_sel[i] + 1'b1) : vec_sel[i];
                  n_in[i]   = '0;
               end
               degen_in = all_zero;
               state_in = all_zero ? N_DONE : N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (any_high) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else if (all_low) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << 1;
            end else begin
               len_in   = '0;
               comp_in  = 2'd0;
               state_in = N_SQUARE;
            end
         end
         N_SQUARE: begin
            len_in = len_ff + LEN_W'(square);
            if (comp_ff == 2'd2) begin
               root_in  = '0;
               bit_in   = LEN_W'(1) << 60;
               state_in = N_SQRT;
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         N_SQRT: begin
            if (len_ff >= trial) begin
               len_in  = len_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               comp_in  = 2'd0;
               state_in = N_DIV_SETUP;
            end
         end
         N_DIV_SETUP: begin
            num_in   = DIV_W'({m_cur, 14'd0}) + DIV_W'(root_s >> 1);
            dvs_in   = DIV_W'(root_s) << 15;
            q_in     = '0;
            cnt_in   = 4'd15;
            state_in = N_DIV;
         end
         N_DIV: begin
            if (ge) num_in = num_ff - dvs_ff;
            dvs_in = dvs_ff >> 1;
            q_in   = {q_ff[NORM_W-2:0], ge};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               q_clamped = (q_in > NORM_W'(ONE_Q14)) ? NORM_W'(ONE_Q14) : q_in;
               n_in[comp_ff] = neg_ff[comp_ff] ? -$signed(q_clamped) : $signed(q_clamped);
               if (comp_ff == 2'd2) begin
                  state_in = N_DONE;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = N_DIV_SETUP;
               end
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   assign norm_rsp.done  = (state_ff == N_DONE);
   assign norm_rsp.degen = degen_ff;
   assign norm_rsp.n_x   = n_ff[0];
   assign norm_rsp.n_y   = n_ff[1];
   assign norm_rsp.n_z   = n_ff[2];

endmodule

// File: hw/rtl/mesh_face_and_vertex_normals.sv
// ----------------------------------------------------------------------------
// Mesh face and smooth vertex normals
// Vertex position store, per-vertex normal sums and a shared normalizer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load gives no
// result. A face goes through three position reads, six products on one
// multiplier, the normalizer (up to 29 shift steps, three squares, 31 square
// root steps and three 16-step divisions) and three read-modify-write
// updates of the sums. A read of a vertex normal spends nearly all of its
// time in the normalizer. Each result appears on rsp_data for exactly one
// cycle with rsp_valid high and cannot be held off. After reset the block
// clears the normal sums one entry a cycle, so busy stays high until every
// entry is cleared, before the first request is taken.
module mesh_face_and_vertex_normals
   import mfvn_pkg::*;
#(
   parameter int unsigned VERTEX_DEPTH = VERTEX_DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

`include "mesh_face_and_vertex_normals_assert.svh"

   localparam int unsigned ADDR_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int unsigned PW = 3 * POS_W;
   localparam int unsigned SW = 3 * SUM_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTEX_DEPTH - 1);

   // Memories.
   logic [PW-1:0] pos_mem [VERTEX_DEPTH];
   logic [SW-1:0] sum_mem [VERTEX_DEPTH];
   logic              pos_we, sum_we;
   logic [ADDR_W-1:0] pos_waddr, pos_raddr, sum_waddr, sum_raddr;
   logic [PW-1:0]     pos_wdata, pos_rdata_ff;
   logic [SW-1:0]     sum_wdata, sum_rdata_ff;

   top_state_type state_ff, state_in;
   req_type           req_ff, req_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [PW-1:0]     pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e1_in [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [EDGE_W-1:0] e2_in [3];
   logic signed [VEC_W-1:0]  vec_ff [3];
   logic signed [VEC_W-1:0]  vec_in [3];
   logic [2:0]        step_ff, step_in;
   logic [1:0]        corner_ff, corner_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   norm_req_type norm_req;
   norm_rsp_type norm_rsp;

   logic signed [EDGE_W-1:0]     op_a, op_b;
   logic signed [2*EDGE_W-1:0]   prod;
   logic [INDEX_W-1:0]           corner_idx;
   logic signed [NORM_W-1:0]     n_sel [3];
   logic signed [SUM_W:0]        sum_ext;
   logic signed [SUM_W-1:0]      sum_new [3];
   logic                         face_ok;

   // Position store.
   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
      pos_rdata_ff <= pos_mem[pos_raddr];
   end

   // Normal sum store.
   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
      sum_rdata_ff <= sum_mem[sum_raddr];
   end

   // Control and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      pc_ff     <= pc_in;
      step_ff   <= step_in;
      corner_ff <= corner_in;
      rsp_ff    <= rsp_in;
      for (int i = 0; i < 3; i++) begin
         e1_ff[i]  <= e1_in[i];
         e2_ff[i]  <= e2_in[i];
         vec_ff[i] <= vec_in[i];
      end
   end

   mfvn_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .norm_req (norm_req),
      .norm_rsp (norm_rsp)
   );

   // Cross product operand selection on the shared multiplier.
   always_comb begin
      case (step_ff)
         3'd0: begin op_a = e1_ff[1]; op_b = e2_ff[2]; end
         3'd1: begin op_a = e1_ff[2]; op_b = e2_ff[1]; end
         3'd2: begin op_a = e1_ff[2]; op_b = e2_ff[0]; end
         3'd3: begin op_a = e1_ff[0]; op_b = e2_ff[2]; end
         3'd4: begin op_a = e1_ff[0]; op_b = e2_ff[1]; end
         3'd5: begin op_a = e1_ff[1]; op_b = e2_ff[0]; end
         default: begin op_a = '0; op_b = '0; end
      endcase
      prod = op_a * op_b;
   end

   // Saturating update of the current corner's sum.
   always_comb begin
      case (corner_ff)
         2'd0:    corner_idx = req_ff.index_a;
         2'd1:    corner_idx = req_ff.index_b;
         default: corner_idx = req_ff.index_c;
      endcase
      n_sel[0] = norm_rsp.n_x;
      n_sel[1] = norm_rsp.n_y;
      n_sel[2] = norm_rsp.n_z;
      sum_ext  = '0;
      for (int i = 0; i < 3; i++) begin
         sum_ext = $signed(sum_rdata_ff[SW-1-i*SUM_W -: SUM_W]) + n_sel[i];
         if (sum_ext > (SUM_W+1)'(2**(SUM_W-1) - 1)) begin
            sum_new[i] = {1'b0, {(SUM_W-1){1'b1}}};
         end else if (sum_ext < -(SUM_W+1)'(2**(SUM_W-1))) begin
            sum_new[i] = {1'b1, {(SUM_W-1){1'b0}}};
         end else begin
            sum_new[i] = sum_ext[SUM_W-1:0];
         end
      end
   end

   assign face_ok = idx_ok(req_data.index_a, VERTEX_DEPTH) &&
                    idx_ok(req_data.index_b, VERTEX_DEPTH) &&
                    idx_ok(req_data.index_c, VERTEX_DEPTH);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      clr_in       = clr_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;
      step_in      = step_ff;
      corner_in    = corner_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      for (int i = 0; i < 3; i++) begin
         e1_in[i]  = e1_ff[i];
         e2_in[i]  = e2_ff[i];
         vec_in[i] = vec_ff[i];
      end
      pos_we    = 1'b0;
      pos_waddr = ADDR_W'(req_ff.index_a);
      pos_wdata = {req_ff.pos_x, req_ff.pos_y, req_ff.pos_z};
      pos_raddr = ADDR_W'(req_ff.index_a);
      sum_we    = 1'b0;
      sum_waddr = ADDR_W'(req_ff.index_a);
      sum_wdata = '0;
      sum_raddr = ADDR_W'(req_ff.index_a);
      norm_req.start = 1'b0;
      norm_req.vec_x = vec_ff[0];
      norm_req.vec_y = vec_ff[1];
      norm_req.vec_z = vec_ff[2];

      case (state_ff)
         T_CLEAR: begin
            sum_we    = 1'b1;
            sum_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) state_in = T_IDLE;
         end
         T_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.mode)
                  MODE_LOAD: state_in = T_LOAD;
                  MODE_FACE: begin
                     if (face_ok) begin
                        state_in = T_FRA;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{is_face: 1'b1, norm_x: '0, norm_y: '0,
                                         norm_z: '0, degenerate: 1'b1};
                     end
                  end
                  MODE_READ: begin
                     if (idx_ok(req_data.index_a, VERTEX_DEPTH)) begin
                        state_in = T_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{is_face: 1'b0, norm_x: '0, norm_y: '0,
                                         norm_z: '0, degenerate: 1'b1};
                     end
                  end
                  default: state_in = T_IDLE;
               endcase
            end
         end
         T_LOAD: begin
            if (idx_ok(req_ff.index_a, VERTEX_DEPTH)) begin
               pos_we = 1'b1;
               sum_we = 1'b1;
            end
            state_in = T_IDLE;
         end
         T_FRA: begin
            state_in = T_FRB;
         end
         T_FRB: begin
            pos_raddr = ADDR_W'(req_ff.index_b);
            pa_in     = pos_rdata_ff;
            state_in  = T_FRC;
         end
         T_FRC: begin
            pos_raddr = ADDR_W'(req_ff.index_c);
            pb_in     = pos_rdata_ff;
            state_in  = T_FCAP;
         end
         T_FCAP: begin
            pc_in    = pos_rdata_ff;
            state_in = T_EDGE;
         end
         T_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = $signed(pb_ff[PW-1-i*POS_W -: POS_W]) -
                          $signed(pa_ff[PW-1-i*POS_W -: POS_W]);
               e2_in[i] = $signed(pc_ff[PW-1-i*POS_W -: POS_W]) -
                          $signed(pa_ff[PW-1-i*POS_W -: POS_W]);
            end
            step_in  = 3'd0;
            state_in = T_MUL;
         end
         T_MUL: begin
            if (step_ff[0]) begin
               vec_in[step_ff[2:1]] = vec_ff[step_ff[2:1]] - VEC_W'(prod);
            end else begin
               vec_in[step_ff[2:1]] = VEC_W'(prod);
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) state_in = T_NGO;
         end
         T_RD: begin
            state_in = T_RDCAP;
         end
         T_RDCAP: begin
            for (int i = 0; i < 3; i++) begin
               vec_in[i] = VEC_W'($signed(sum_rdata_ff[SW-1-i*SUM_W -: SUM_W]));
            end
            state_in = T_NGO;
         end
         T_NGO: begin
            norm_req.start = 1'b1;
            state_in       = T_NWAIT;
         end
         T_NWAIT: begin
            if (norm_rsp.done) begin
               if (req_ff.mode == MODE_FACE) begin
                  corner_in = 2'd0;
                  state_in  = T_ACC_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{is_face: 1'b0, norm_x: norm_rsp.n_x,
                                   norm_y: norm_rsp.n_y, norm_z: norm_rsp.n_z,
                                   degenerate: norm_rsp.degen};
                  state_in     = T_IDLE;
               end
            end
         end
         T_ACC_RD: begin
            sum_raddr = ADDR_W'(corner_idx);
            state_in  = T_ACC_WR;
         end
         T_ACC_WR: begin
            sum_we    = 1'b1;
            sum_waddr = ADDR_W'(corner_idx);
            sum_wdata = {sum_new[0], sum_new[1], sum_new[2]};
            if (corner_ff == 2'd2) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{is_face: 1'b1, norm_x: norm_rsp.n_x,
                                norm_y: norm_rsp.n_y, norm_z: norm_rsp.n_z,
                                degenerate: norm_rsp.degen};
               state_in     = T_IDLE;
            end else begin
               corner_in = corner_ff + 2'd1;
               state_in  = T_ACC_RD;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != T_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks on the sequencer and the results.
   `MFVN_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `MFVN_ASSERT_NEXT(a_load_no_rsp, clock, reset,
      start && !busy && (req_data.mode == MODE_LOAD), !rsp_valid)
   `MFVN_ASSERT_NOW(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate,
      (rsp_data.norm_x == '0) && (rsp_data.norm_y == '0) && (rsp_data.norm_z == '0))

endmodule
